// ----- rtl/rat_pkg.sv -----
`default_nettype none
package rat_pkg;

  // Operation codes carried on the input tuser.
  localparam logic [2:0] FUNC_LOAD = 3'd0;
  localparam logic [2:0] FUNC_ADD  = 3'd1;
  localparam logic [2:0] FUNC_SUB  = 3'd2;
  localparam logic [2:0] FUNC_MUL  = 3'd3;
  localparam logic [2:0] FUNC_DIV  = 3'd4;

  // Status codes carried on the output tuser.
  localparam logic [1:0] STAT_OK   = 2'd0;
  localparam logic [1:0] STAT_ZERO = 2'd1;
  localparam logic [1:0] STAT_OVF  = 2'd2;

  localparam int DEF_WIDTH = 32;

  typedef enum logic [3:0] {
    ST_IDLE, ST_MUL0, ST_MUL1, ST_MUL2, ST_MUL3, ST_COMB,
    ST_GTWO, ST_GLOOP, ST_DIVN, ST_DIVD, ST_STORE, ST_OUT
  } state_t;

endpackage
`default_nettype wire

// ----- rtl/rat_mul.sv -----
`default_nettype none
module rat_mul (
  input  wire logic        clk,
  input  wire logic [31:0] a,
  input  wire logic [31:0] b,
  output logic [63:0]      prod
);

  // Registered 32x32 unsigned product.
  always_ff @(posedge clk) begin
    prod <= {32'd0, a} * {32'd0, b};
  end

endmodule
`default_nettype wire

// ----- rtl/rat_div.sv -----
`default_nettype none
module rat_div (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  input  wire logic [63:0] dividend,
  input  wire logic [63:0] divisor,
  output logic             done,
  output logic [63:0]      quotient
);

  logic [63:0] rem_r;
  logic [63:0] quo_r;
  logic [63:0] dvs_r;
  logic [5:0]  cnt_r;
  logic        busy_r;
  logic        done_r;
  logic [64:0] shifted;
  logic        fits;

  // One restoring step: shift in the next dividend bit and try a subtract.
  assign shifted = {rem_r, quo_r[63]};
  assign fits    = shifted >= {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
      end else if (busy_r && cnt_r == 6'd63) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= dividend;
      dvs_r <= divisor;
      cnt_r <= '0;
    end else if (busy_r) begin
      rem_r <= fits ? 64'(shifted - {1'b0, dvs_r}) : shifted[63:0];
      quo_r <= {quo_r[62:0], fits};
      cnt_r <= cnt_r + 6'd1;
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule
`default_nettype wire

// ----- rtl/rational_accumulator_alu_unit.sv -----
`default_nettype none
// Rational accumulator: holds a fraction num/den (sign on the numerator) and
// applies load, add, subtract, multiply or divide with the operand fraction,
// reducing arithmetic results by the gcd. One item at a time: ready only
// when idle. Arithmetic forms three products on one shared 32x32
// multiplier, runs a binary gcd on the 64-bit products, and makes two
// divisions on one shared restoring divider. The result waits in an output
// register; a new item may be accepted meanwhile, and its own result is held
// back until that register has been handed over.
module rational_accumulator_alu_unit #(
  parameter int WIDTH = rat_pkg::DEF_WIDTH
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [63:0] in_tdata,  // operand_num[31:0], operand_den[63:32]
  input  wire logic [2:0]  in_tuser,  // func[2:0]
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [63:0]      out_tdata, // result_num[31:0], result_den[62:32], zero pad
  output logic [1:0]       out_tuser  // status[1:0]
);

  localparam logic [63:0] LIM = (64'd1 << (WIDTH - 1)) - 64'd1;

  rat_pkg::state_t state_r, state_nxt;
  logic [31:0] acc_num_r, acc_num_nxt;
  logic [31:0] acc_den_r, acc_den_nxt;
  logic [2:0]  func_r, func_nxt;
  logic [31:0] n1_r, n1_nxt, d1_r, d1_nxt, n2_r, n2_nxt, d2_r, d2_nxt;
  logic        sa_r, sa_nxt, s2_r, s2_nxt;
  logic [63:0] p_r, p_nxt, q_r, q_nxt, dd_r, dd_nxt;
  logic [63:0] n_r, n_nxt, d_r, d_nxt, ga_r, ga_nxt, gb_r, gb_nxt, g_r, g_nxt;
  logic        neg_r, neg_nxt;
  logic [5:0]  k_r, k_nxt;
  logic [1:0]  stat_r, stat_nxt;
  logic        ov_r, ov_nxt;
  logic [31:0] onum_r, onum_nxt;
  logic [30:0] oden_r, oden_nxt;
  logic [1:0]  ostat_r, ostat_nxt;

  logic [31:0] mul_a, mul_b;
  logic [63:0] prod;
  logic        div_start, div_done;
  logic [63:0] div_dvd, div_dvs, quo;
  logic [31:0] in_num, in_den, mag_num, mag_den;
  logic        sq, ovf;

  rat_mul u_mul (.clk(clk), .a(mul_a), .b(mul_b), .prod(prod));

  rat_div u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start), .dividend(div_dvd),
    .divisor(div_dvs), .done(div_done), .quotient(quo)
  );

  // Magnitudes of the incoming operand fields.
  assign in_num  = in_tdata[31:0];
  assign in_den  = in_tdata[63:32];
  assign mag_num = in_num[31] ? (32'd0 - in_num) : in_num;
  assign mag_den = in_den[31] ? (32'd0 - in_den) : in_den;

  assign sq  = (func_r == rat_pkg::FUNC_SUB) ? !s2_r : s2_r;
  assign ovf = (d_r > LIM) || ((neg_r && n_r != 64'd0) ? (n_r > LIM + 64'd1) : (n_r > LIM));

  assign in_tready  = (state_r == rat_pkg::ST_IDLE);
  assign out_tvalid = ov_r;
  assign out_tdata  = {1'b0, oden_r, onum_r};
  assign out_tuser  = ostat_r;

  // Sequencer and datapath next-state logic.
  always_comb begin
    state_nxt = state_r;
    acc_num_nxt = acc_num_r; acc_den_nxt = acc_den_r;
    func_nxt = func_r; n1_nxt = n1_r; d1_nxt = d1_r; n2_nxt = n2_r; d2_nxt = d2_r;
    sa_nxt = sa_r; s2_nxt = s2_r;
    p_nxt = p_r; q_nxt = q_r; dd_nxt = dd_r;
    n_nxt = n_r; d_nxt = d_r; ga_nxt = ga_r; gb_nxt = gb_r; g_nxt = g_r;
    neg_nxt = neg_r; k_nxt = k_r; stat_nxt = stat_r;
    ov_nxt = ov_r; onum_nxt = onum_r; oden_nxt = oden_r; ostat_nxt = ostat_r;
    mul_a = d1_r; mul_b = d2_r;
    div_start = 1'b0; div_dvd = n_r; div_dvs = g_r;

    if (ov_r && out_tready) begin
      ov_nxt = 1'b0;
    end

    unique case (state_r)
      rat_pkg::ST_IDLE: begin
        if (in_tvalid) begin
          func_nxt = in_tuser;
          n2_nxt = mag_num; d2_nxt = mag_den;
          s2_nxt = in_num[31] != in_den[31];
          sa_nxt = acc_num_r[31];
          n1_nxt = acc_num_r[31] ? (32'd0 - acc_num_r) : acc_num_r;
          d1_nxt = acc_den_r;
          stat_nxt = rat_pkg::STAT_OK;
          if (in_tuser > rat_pkg::FUNC_DIV) begin
            state_nxt = rat_pkg::ST_OUT;
          end else if (mag_den == 32'd0 ||
                       (in_tuser == rat_pkg::FUNC_DIV && mag_num == 32'd0)) begin
            stat_nxt = rat_pkg::STAT_ZERO;
            state_nxt = rat_pkg::ST_OUT;
          end else if (in_tuser == rat_pkg::FUNC_LOAD) begin
            n_nxt = {32'd0, mag_num};
            d_nxt = {32'd0, mag_den};
            neg_nxt = in_num[31] != in_den[31];
            state_nxt = rat_pkg::ST_STORE;
          end else begin
            state_nxt = rat_pkg::ST_MUL0;
          end
        end
      end
      // Three products through the one multiplier.
      rat_pkg::ST_MUL0: begin
        mul_a = n1_r;
        mul_b = (func_r == rat_pkg::FUNC_MUL) ? n2_r : d2_r;
        state_nxt = rat_pkg::ST_MUL1;
      end
      rat_pkg::ST_MUL1: begin
        p_nxt = prod;
        mul_a = n2_r; mul_b = d1_r;
        state_nxt = rat_pkg::ST_MUL2;
      end
      rat_pkg::ST_MUL2: begin
        q_nxt = prod;
        mul_a = d1_r;
        mul_b = (func_r == rat_pkg::FUNC_DIV) ? n2_r : d2_r;
        state_nxt = rat_pkg::ST_MUL3;
      end
      rat_pkg::ST_MUL3: begin
        dd_nxt = prod;
        state_nxt = rat_pkg::ST_COMB;
      end
      // Form the signed numerator, then start the gcd unless it is zero.
      rat_pkg::ST_COMB: begin
        d_nxt = dd_r;
        if (func_r == rat_pkg::FUNC_ADD || func_r == rat_pkg::FUNC_SUB) begin
          if (sa_r == sq) begin
            n_nxt = p_r + q_r; neg_nxt = sa_r;
          end else if (p_r >= q_r) begin
            n_nxt = p_r - q_r; neg_nxt = sa_r;
          end else begin
            n_nxt = q_r - p_r; neg_nxt = sq;
          end
        end else begin
          n_nxt = p_r;
          neg_nxt = sa_r != s2_r;
        end
        if (n_nxt == 64'd0) begin
          d_nxt = 64'd1; neg_nxt = 1'b0;
          state_nxt = rat_pkg::ST_STORE;
        end else begin
          ga_nxt = n_nxt; gb_nxt = dd_r; k_nxt = '0;
          state_nxt = rat_pkg::ST_GTWO;
        end
      end
      // Binary gcd: pull out common factors of two first.
      rat_pkg::ST_GTWO: begin
        if (!ga_r[0] && !gb_r[0]) begin
          ga_nxt = ga_r >> 1; gb_nxt = gb_r >> 1; k_nxt = k_r + 6'd1;
        end else begin
          state_nxt = rat_pkg::ST_GLOOP;
        end
      end
      rat_pkg::ST_GLOOP: begin
        if (gb_r == 64'd0) begin
          g_nxt = ga_r << k_r;
          div_start = 1'b1; div_dvd = n_r; div_dvs = ga_r << k_r;
          state_nxt = rat_pkg::ST_DIVN;
        end else if (!ga_r[0]) begin
          ga_nxt = ga_r >> 1;
        end else if (!gb_r[0]) begin
          gb_nxt = gb_r >> 1;
        end else if (ga_r >= gb_r) begin
          // Both odd: keep the smaller one and pass the even difference on.
          ga_nxt = gb_r; gb_nxt = ga_r - gb_r;
        end else begin
          gb_nxt = gb_r - ga_r;
        end
      end
      rat_pkg::ST_DIVN: begin
        if (div_done) begin
          n_nxt = quo;
          div_start = 1'b1; div_dvd = d_r; div_dvs = g_r;
          state_nxt = rat_pkg::ST_DIVD;
        end
      end
      rat_pkg::ST_DIVD: begin
        if (div_done) begin
          d_nxt = quo;
          state_nxt = rat_pkg::ST_STORE;
        end
      end
      // Range check; the accumulator changes only when the result fits.
      rat_pkg::ST_STORE: begin
        if (ovf) begin
          stat_nxt = rat_pkg::STAT_OVF;
        end else begin
          acc_num_nxt = neg_r ? (32'd0 - n_r[31:0]) : n_r[31:0];
          acc_den_nxt = d_r[31:0];
        end
        state_nxt = rat_pkg::ST_OUT;
      end
      rat_pkg::ST_OUT: begin
        if (!ov_r || out_tready) begin
          ov_nxt = 1'b1;
          onum_nxt = acc_num_r;
          oden_nxt = acc_den_r[30:0];
          ostat_nxt = stat_r;
          state_nxt = rat_pkg::ST_IDLE;
        end
      end
      default: state_nxt = rat_pkg::ST_IDLE;
    endcase
  end

  // Control state and accumulator.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= rat_pkg::ST_IDLE;
      acc_num_r <= 32'd0;
      acc_den_r <= 32'd1;
      ov_r      <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      acc_num_r <= acc_num_nxt;
      acc_den_r <= acc_den_nxt;
      ov_r      <= ov_nxt;
    end
  end

  // Working registers.
  always_ff @(posedge clk) begin
    func_r <= func_nxt; n1_r <= n1_nxt; d1_r <= d1_nxt; n2_r <= n2_nxt; d2_r <= d2_nxt;
    sa_r <= sa_nxt; s2_r <= s2_nxt;
    p_r <= p_nxt; q_r <= q_nxt; dd_r <= dd_nxt;
    n_r <= n_nxt; d_r <= d_nxt; ga_r <= ga_nxt; gb_r <= gb_nxt; g_r <= g_nxt;
    neg_r <= neg_nxt; k_r <= k_nxt; stat_r <= stat_nxt;
    onum_r <= onum_nxt; oden_r <= oden_nxt; ostat_r <= ostat_nxt;
  end

endmodule
`default_nettype wire
